@@ hdl/deq_pkg.sv @@
`default_nettype none

package deq_pkg;

	localparam int DEPTH = 1024;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CNT_W:0] wide_t;

	typedef enum logic [2:0] {
		CMD_PEEK_FRONT = 3'd0,
		CMD_PEEK_BACK  = 3'd1,
		CMD_PUSH_FRONT = 3'd2,
		CMD_PUSH_BACK  = 3'd3,
		CMD_POP_FRONT  = 3'd4,
		CMD_POP_BACK   = 3'd5,
		CMD_CLEAR      = 3'd6
	} command_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_READ = 1'b1
	} state_t;

	typedef struct packed {
		logic accept;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic needs_read;
	} ctl_stat_t;

	function automatic idx_t wrap_add(input idx_t base, input cnt_t offset);
		wide_t sum;
		begin
			sum = wide_t'(base) + wide_t'(offset);
			if (sum >= wide_t'(DEPTH)) begin
				sum = sum - wide_t'(DEPTH);
			end
			return idx_t'(sum);
		end
	endfunction

endpackage

`default_nettype wire

@@ hdl/deq_ctrl.sv @@
`default_nettype none

module deq_ctrl
	import deq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire ctl_stat_t stat,
	output ctl_cmd_t       cmd
);

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   load;

	always_comb begin
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.accept && stat.needs_read) begin
					state_next = S_READ;
				end
			end
			S_READ: begin
				state_next = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = !out_valid_q || out_ready;
			end
			S_READ: begin
				cmd.finish = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		cmd.accept = in_valid && in_ready;
		load       = (cmd.accept && !stat.needs_read) || cmd.finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ hdl/deq_datapath.sv @@
`default_nettype none

module deq_datapath
	import deq_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire ctl_cmd_t                 cmd,
	output ctl_stat_t                     stat,
	input  wire logic [2:0]               command,
	input  wire logic signed [DATA_W-1:0] push_value,
	output logic [1:0]                    status,
	output logic signed [DATA_W-1:0]      read_value,
	output logic [CNT_W-1:0]              element_count
);

	logic [DATA_W-1:0] store_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	idx_t              head_q;
	cnt_t              count_q;

	status_t           status_q;
	cnt_t              out_count_q;
	logic [DATA_W-1:0] read_value_q;

	command_t          op;
	logic              is_empty;
	logic              is_full;
	idx_t              back_idx;
	idx_t              rd_addr;
	idx_t              wr_addr;
	logic              wr_en;
	idx_t              head_next;
	cnt_t              count_next;
	status_t           status_next;
	logic              needs_read;

	always_comb begin
		op          = command_t'(command);
		is_empty    = (count_q == '0);
		is_full     = (count_q >= cnt_t'(DEPTH));
		back_idx    = wrap_add(head_q, count_q - cnt_t'(1));
		rd_addr     = head_q;
		wr_addr     = head_q;
		wr_en       = 1'b0;
		head_next   = head_q;
		count_next  = count_q;
		status_next = ST_OK;
		needs_read  = 1'b0;
		case (op)
			CMD_PEEK_FRONT, CMD_POP_FRONT: begin
				if (is_empty) begin
					status_next = ST_EMPTY;
				end else begin
					needs_read = 1'b1;
					rd_addr    = head_q;
					if (op == CMD_POP_FRONT) begin
						head_next  = wrap_add(head_q, cnt_t'(1));
						count_next = count_q - cnt_t'(1);
					end
				end
			end
			CMD_PEEK_BACK, CMD_POP_BACK: begin
				if (is_empty) begin
					status_next = ST_EMPTY;
				end else begin
					needs_read = 1'b1;
					rd_addr    = back_idx;
					if (op == CMD_POP_BACK) begin
						count_next = count_q - cnt_t'(1);
					end
				end
			end
			CMD_PUSH_FRONT: begin
				if (is_full) begin
					status_next = ST_FULL;
				end else begin
					head_next  = wrap_add(head_q, cnt_t'(DEPTH - 1));
					wr_addr    = head_next;
					wr_en      = 1'b1;
					count_next = count_q + cnt_t'(1);
				end
			end
			CMD_PUSH_BACK: begin
				if (is_full) begin
					status_next = ST_FULL;
				end else begin
					wr_addr    = wrap_add(head_q, count_q);
					wr_en      = 1'b1;
					count_next = count_q + cnt_t'(1);
				end
			end
			CMD_CLEAR: begin
				head_next  = '0;
				count_next = '0;
			end
			default: begin
				status_next = ST_OK;
			end
		endcase
		stat.needs_read = needs_read;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && wr_en) begin
			store_q[wr_addr] <= push_value;
		end
		if (cmd.accept && needs_read) begin
			rd_data_q <= store_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			head_q  <= head_next;
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			status_q     <= status_next;
			out_count_q  <= count_next;
			read_value_q <= '0;
		end else if (cmd.finish) begin
			read_value_q <= rd_data_q;
		end
	end

	assign status        = status_q;
	assign read_value    = read_value_q;
	assign element_count = out_count_q;

endmodule

`default_nettype wire

@@ hdl/double_ended_queue_unit.sv @@
`default_nettype none

// Bounded double-ended queue of signed 32-bit values held in a 1024-entry circular
// store, with one result beat for every command beat. Push, clear, unused command
// codes and any command refused with an error load their result when accepted; a
// peek or pop that reads an element passes through an extra read state, because the
// store has a single registered read port and the value must pass through it first.
// A new command is taken as soon as the previous result has been loaded into the
// output register and that register is free or being emptied in the same cycle.
// The store needs no clearing pass after reset: only entries written by a push are
// ever read.

module double_ended_queue_unit
	import deq_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [2:0]               command,
	input  wire logic signed [DATA_W-1:0] push_value,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [1:0]                    status,
	output logic signed [DATA_W-1:0]      read_value,
	output logic [CNT_W-1:0]              element_count
);

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	deq_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.command       (command),
		.push_value    (push_value),
		.status        (status),
		.read_value    (read_value),
		.element_count (element_count)
	);

endmodule

`default_nettype wire

@@ hdl/deq_checker.sv @@
`default_nettype none

module deq_checker
	import deq_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     out_valid,
	input wire logic                     out_ready,
	input wire logic [1:0]               status,
	input wire logic signed [DATA_W-1:0] read_value,
	input wire logic [CNT_W-1:0]         element_count
);

	// A refused push only happens with the store full.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (element_count == CNT_W'(DEPTH)))
		else $error("full status with a store that is not full");

	// An empty error leaves nothing stored and reads nothing.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (element_count == '0 && read_value == '0))
		else $error("empty status with elements or a non-zero value");

	// The count never exceeds the capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (element_count <= CNT_W'(DEPTH)))
		else $error("element count beyond capacity");

	// A stalled result beat holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(read_value) && $stable(status)))
		else $error("result beat changed while stalled");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.read_value    (read_value),
	.element_count (element_count)
);

`default_nettype wire
